// File: sv/fpwm_pkg.sv
// Shared types and constants of the fading PWM LED driver.
`timescale 1ns / 1ps

package fpwm_pkg;

    localparam int LEVEL_W = 8;
    localparam int CMD_W   = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 8'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_UNSET = 8'd255;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FADE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_DIV
    } t_state;

endpackage

// File: sv/fpwm_div.sv
// Restoring divider that produces one quotient bit per cycle.
`timescale 1ns / 1ps

module fpwm_div #(
    parameter int DIVIDEND_W = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [DIVIDEND_W-1:0]          i_dividend,
    input  logic [fpwm_pkg::LEVEL_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [DIVIDEND_W-1:0]          o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W);
    localparam int DV_W  = fpwm_pkg::LEVEL_W;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quot;
    logic [DV_W-1:0]       r_rem;
    logic [DV_W-1:0]       r_divisor;

    logic [DV_W:0]         rem_shift;
    logic                  fits;
    logic [DV_W:0]         rem_diff;

    assign rem_shift = {r_rem, r_quot[DIVIDEND_W-1]};
    assign fits      = rem_shift >= {1'b0, r_divisor};
    assign rem_diff  = rem_shift - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot    <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DIVIDEND_W-2:0], fits};
            r_rem  <= fits ? rem_diff[DV_W-1:0] : rem_shift[DV_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quot;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider reports done while still busy");

    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a preceding division");

endmodule

// File: sv/fading_pwm_led_driver_top.sv
// Top level of the fading PWM LED driver: command decode, PWM tick and fade sequencer.
`timescale 1ns / 1ps

// A tick, an immediate set or an ignored command is handled as it is taken, and a tick
// places its result in the output register, from where it is handed on while the
// next command is already being taken. A fade set that follows at least one tick
// since the previous set runs a restoring divider that yields one quotient bit per
// cycle, so s_axis_tready stays low while the divider runs, and the next command is
// taken only once the quotient has been stored.

module fading_pwm_led_driver_top #(
    parameter int PWM_STEPS        = 100,
    parameter int TICK_COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] level
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [0] pin_on, [8:1] current_level, rest zero
);

    localparam int LW = fpwm_pkg::LEVEL_W;
    localparam int PW = $clog2(PWM_STEPS);
    localparam int TW = TICK_COUNT_WIDTH;

    fpwm_pkg::t_state r_state, n_state;

    logic [PW-1:0] r_phase, n_phase;
    logic [LW-1:0] r_level_now, n_level_now;
    logic [LW-1:0] r_fade_start, n_fade_start;
    logic [LW-1:0] r_fade_target, n_fade_target;
    logic [TW-1:0] r_tss, n_tss;
    logic [TW-1:0] r_tpp, n_tpp;
    logic [TW-1:0] r_tts, n_tts;
    logic          r_rising, n_rising;
    logic          r_out_valid, n_out_valid;
    logic          r_out_pin, n_out_pin;
    logic [LW-1:0] r_out_level, n_out_level;

    logic          accept;
    logic [LW-1:0] pct;
    logic [LW-1:0] diff_raw;
    logic [LW-1:0] diff;
    logic          up;
    logic [LW:0]   lvl_inc;
    logic [LW-1:0] lvl_step;
    logic          div_start;
    logic          div_done;
    logic [TW-1:0] div_quot;

    assign s_axis_tready = (r_state == fpwm_pkg::ST_IDLE) && (!r_out_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign pct      = (s_axis_tdata > fpwm_pkg::LEVEL_MAX) ? fpwm_pkg::LEVEL_MAX : s_axis_tdata;
    assign up       = pct > r_fade_target;
    assign diff_raw = up ? (pct - r_fade_target) : (r_fade_target - pct);
    assign diff     = (diff_raw == '0) ? LW'(1) : diff_raw;

    assign lvl_inc = {1'b0, r_level_now} + 1'b1;

    always_comb begin
        if (r_rising) begin
            lvl_step = (lvl_inc > {1'b0, r_fade_target}) ? r_fade_target : lvl_inc[LW-1:0];
        end else if (r_level_now == '0 || (r_level_now - 1'b1) < r_fade_target) begin
            lvl_step = r_fade_target;
        end else begin
            lvl_step = r_level_now - 1'b1;
        end
    end

    assign div_start = accept && s_axis_tuser == fpwm_pkg::CMD_FADE && r_tss != '0;

    fpwm_div #(
        .DIVIDEND_W(TW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_tss),
        .i_divisor  (diff),
        .o_done     (div_done),
        .o_quotient (div_quot)
    );

    always_comb begin
        n_state       = r_state;
        n_phase       = r_phase;
        n_level_now   = r_level_now;
        n_fade_start  = r_fade_start;
        n_fade_target = r_fade_target;
        n_tss         = r_tss;
        n_tpp         = r_tpp;
        n_tts         = r_tts;
        n_rising      = r_rising;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_pin     = r_out_pin;
        n_out_level   = r_out_level;

        unique case (r_state)
            fpwm_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (s_axis_tuser)
                        fpwm_pkg::CMD_TICK: begin
                            n_out_valid = 1'b1;
                            n_out_pin   = LW'(r_phase) < r_level_now;
                            n_out_level = r_level_now;
                            n_phase     = (r_phase == PW'(PWM_STEPS - 1)) ? '0 : r_phase + 1'b1;
                            if (r_tts <= TW'(1)) begin
                                n_tts       = r_tpp;
                                n_level_now = lvl_step;
                            end else begin
                                n_tts = r_tts - 1'b1;
                            end
                            if (r_tss != '1) begin
                                n_tss = r_tss + 1'b1;
                            end
                        end
                        fpwm_pkg::CMD_FADE: begin
                            n_fade_start  = r_fade_target;
                            n_fade_target = pct;
                            n_level_now   = (r_fade_target == fpwm_pkg::LEVEL_UNSET) ?
                                            pct : r_fade_target;
                            n_tss         = '0;
                            if (div_start) begin
                                n_rising = up;
                                n_state  = fpwm_pkg::ST_DIV;
                            end
                        end
                        fpwm_pkg::CMD_SET: begin
                            n_fade_start  = pct;
                            n_fade_target = pct;
                            n_level_now   = pct;
                            n_tpp         = r_tss;
                            n_tss         = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            fpwm_pkg::ST_DIV: begin
                if (div_done) begin
                    n_tpp   = div_quot;
                    n_state = fpwm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fpwm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fpwm_pkg::ST_IDLE;
            r_phase       <= '0;
            r_level_now   <= '0;
            r_fade_start  <= fpwm_pkg::LEVEL_UNSET;
            r_fade_target <= fpwm_pkg::LEVEL_UNSET;
            r_tss         <= '0;
            r_tpp         <= '0;
            r_tts         <= '0;
            r_rising      <= 1'b1;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_phase       <= n_phase;
            r_level_now   <= n_level_now;
            r_fade_start  <= n_fade_start;
            r_fade_target <= n_fade_target;
            r_tss         <= n_tss;
            r_tpp         <= n_tpp;
            r_tts         <= n_tts;
            r_rising      <= n_rising;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_pin   <= n_out_pin;
        r_out_level <= n_out_level;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(16 - LW - 1){1'b0}}, r_out_level, r_out_pin};

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == fpwm_pkg::ST_DIV |-> !s_axis_tready)
        else $error("command taken while the divider is running");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= PW'(PWM_STEPS - 1))
        else $error("phase counter out of range");

    a_fade_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |=> r_state == fpwm_pkg::ST_DIV)
        else $error("fade set did not enter the division state");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == fpwm_pkg::ST_DIV)
        else $error("quotient delivered outside the division state");

endmodule

// File: bench/tb.sv
// Self-checking bench for the fading PWM LED driver: queued commands, live prediction.
`timescale 1ns / 1ps

module tb;

    localparam int PHASES = 100;
    localparam int TICK_W = 16;
    localparam logic [fpwm_pkg::CMD_W-1:0] CMD_NONE = 2'd3;
    localparam int HOLD_CYCLES = 500;
    localparam int RANDOM_ITEMS = 1020;

    typedef struct packed {
        logic [fpwm_pkg::CMD_W-1:0]   cmd;
        logic [fpwm_pkg::LEVEL_W-1:0] lvl;
    } t_pwm_cmd;

    typedef struct packed {
        logic                         pin;
        logic [fpwm_pkg::LEVEL_W-1:0] level;
    } t_pwm_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [7:0] level
    logic [1:0]  s_axis_tuser = '0;    // [1:0] command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // [0] pin_on, [8:1] current_level, [15:9] zero

    t_pwm_cmd cmd_q[$];
    t_pwm_out pwm_out_q[$];
    t_pwm_cmd drv_item;

    bit no_idle = 1'b0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int errors = 0;
    int ticks_checked = 0;
    int fades_seen = 0;
    int jumps_seen = 0;
    int ignored_seen = 0;
    int queued = 0;

    logic [6:0]        mdl_phase;
    logic [7:0]        mdl_level;
    logic [7:0]        mdl_from;
    logic [7:0]        mdl_to;
    logic [TICK_W-1:0] mdl_tick_cnt;
    logic [TICK_W-1:0] mdl_rate;
    logic [TICK_W:0]   mdl_countdown;
    logic              mdl_up;

    fading_pwm_led_driver_top #(
        .PWM_STEPS       (PHASES),
        .TICK_COUNT_WIDTH(TICK_W)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    task automatic pwm_clear();
        mdl_phase     = '0;
        mdl_level     = '0;
        mdl_from      = fpwm_pkg::LEVEL_UNSET;
        mdl_to        = fpwm_pkg::LEVEL_UNSET;
        mdl_tick_cnt  = '0;
        mdl_rate      = '0;
        mdl_countdown = '0;
        mdl_up        = 1'b1;
    endtask

    task automatic pwm_predict(input logic [fpwm_pkg::CMD_W-1:0] cmd,
                               input logic [fpwm_pkg::LEVEL_W-1:0] lvl);
        logic [7:0] pct;
        logic [7:0] span;
        logic [8:0] nxt;
        t_pwm_out   res;
        pct = (lvl > fpwm_pkg::LEVEL_MAX) ? fpwm_pkg::LEVEL_MAX : lvl;
        case (cmd) inside
            fpwm_pkg::CMD_FADE, fpwm_pkg::CMD_SET: begin
                if (cmd == fpwm_pkg::CMD_SET) begin
                    jumps_seen++;
                    mdl_from = pct;
                    mdl_to   = pct;
                    mdl_rate = mdl_tick_cnt;
                end else begin
                    fades_seen++;
                    mdl_from = mdl_to;
                    mdl_to   = pct;
                    // With no tick since the last set, the old direction and rate stand.
                    if (mdl_tick_cnt != 0) begin
                        if (mdl_to > mdl_from) begin
                            span   = mdl_to - mdl_from;
                            mdl_up = 1'b1;
                        end else begin
                            span   = mdl_from - mdl_to;
                            mdl_up = 1'b0;
                        end
                        if (span == 0)
                            span = 8'd1;
                        mdl_rate = mdl_tick_cnt / span;
                    end
                end
                mdl_level    = (mdl_from == fpwm_pkg::LEVEL_UNSET) ? pct : mdl_from;
                mdl_tick_cnt = '0;
            end
            fpwm_pkg::CMD_TICK: begin
                res.level = mdl_level;
                res.pin   = (mdl_phase < mdl_level);
                mdl_phase = (int'(mdl_phase) + 1 >= PHASES) ? 7'd0 : mdl_phase + 7'd1;
                if (mdl_countdown <= 1) begin
                    mdl_countdown = {1'b0, mdl_rate};
                    if (mdl_up) begin
                        nxt       = {1'b0, mdl_level} + 9'd1;
                        mdl_level = (nxt > {1'b0, mdl_to}) ? mdl_to : nxt[7:0];
                    end else if (mdl_level == 0 || mdl_level - 8'd1 < mdl_to) begin
                        mdl_level = mdl_to;
                    end else begin
                        mdl_level = mdl_level - 8'd1;
                    end
                end else begin
                    mdl_countdown = mdl_countdown - 1'b1;
                end
                if (mdl_tick_cnt != '1)
                    mdl_tick_cnt = mdl_tick_cnt + 1'b1;
                pwm_out_q.push_back(res);
            end
            default: begin
                ignored_seen++;
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (cmd_q.size() != 0 && (no_idle || $urandom_range(0, 99) >= 16)) begin
                drv_item = cmd_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= drv_item.lvl;
                s_axis_tuser  <= drv_item.cmd;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_seen != hold_req) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 16);
        end
    end

    // Results are checked before the input transfer of the same edge is predicted,
    // since a result can never leave on the edge that takes its tick.
    always @(posedge i_clk) begin
        t_pwm_out want;
        if (!i_rst_n) begin
            pwm_clear();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pwm_out_q.size() == 0) begin
                    report("unexpected result transfer", int'(m_axis_tdata), 0);
                end else begin
                    want = pwm_out_q.pop_front();
                    ticks_checked++;
                    if (m_axis_tdata[0] !== want.pin)
                        report("pin_on", int'(m_axis_tdata[0]), int'(want.pin));
                    if (m_axis_tdata[8:1] !== want.level)
                        report("current_level", int'(m_axis_tdata[8:1]), int'(want.level));
                    if (m_axis_tdata[15:9] !== '0)
                        report("padding bits", int'(m_axis_tdata[15:9]), 0);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pwm_predict(s_axis_tuser, s_axis_tdata);
        end
    end

    task automatic queue_cmd(input logic [fpwm_pkg::CMD_W-1:0] cmd,
                             input logic [fpwm_pkg::LEVEL_W-1:0] lvl);
        t_pwm_cmd c;
        c.cmd = cmd;
        c.lvl = lvl;
        cmd_q.push_back(c);
        queued++;
    endtask

    task automatic queue_ticks(input int n);
        for (int i = 0; i < n; i++)
            queue_cmd(fpwm_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
    endtask

    function automatic logic [7:0] pick_level();
        int r;
        int pick;
        r = $urandom_range(0, 99);
        pick = $urandom_range(0, 4);
        if (r < 70)
            return 8'($urandom_range(0, 100));
        if (r < 85)
            return 8'($urandom_range(101, 255));
        case (pick)
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd99;
            3: return 8'd100;
            default: return 8'd255;
        endcase
    endfunction

    // Fade sets, immediate sets and ignored commands separated by runs of ticks, so that fades of every speed play out.
    task automatic queue_random(input int n);
        int target;
        int r;
        int run;
        target = queued + n;
        while (queued < target) begin
            r = $urandom_range(0, 99);
            if (r < 55)
                queue_cmd(fpwm_pkg::CMD_FADE, pick_level());
            else if (r < 90)
                queue_cmd(fpwm_pkg::CMD_SET, pick_level());
            else
                queue_cmd(CMD_NONE, 8'($urandom_range(0, 255)));
            r = $urandom_range(0, 99);
            if (r < 60)
                run = $urandom_range(0, 20);
            else if (r < 90)
                run = $urandom_range(20, 250);
            else
                run = $urandom_range(250, 600);
            if (run > target - queued)
                run = target - queued;
            queue_ticks(run);
        end
    endtask

    task automatic drain_input();
        while (cmd_q.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
    endtask

    initial begin
        int waited;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Before any set the level climbs one per tick towards the unset target.
        queue_ticks(3);
        queue_cmd(CMD_NONE, 8'd255);
        queue_cmd(fpwm_pkg::CMD_FADE, 8'd50);
        queue_ticks(2);
        queue_cmd(fpwm_pkg::CMD_FADE, 8'd200);
        queue_cmd(fpwm_pkg::CMD_FADE, 8'd100);
        queue_ticks(3);
        queue_cmd(fpwm_pkg::CMD_SET, 8'd0);
        queue_cmd(fpwm_pkg::CMD_TICK, 8'd0);
        queue_cmd(fpwm_pkg::CMD_SET, 8'd255);
        queue_ticks(2);
        queue_cmd(fpwm_pkg::CMD_FADE, 8'd100);
        queue_ticks(2);
        queue_cmd(fpwm_pkg::CMD_SET, 8'd101);
        queue_cmd(fpwm_pkg::CMD_FADE, 8'd0);
        queue_cmd(fpwm_pkg::CMD_TICK, 8'hff);
        queue_cmd(CMD_NONE, 8'd0);
        queue_ticks(2);

        queue_random(RANDOM_ITEMS / 3);
        drain_input();

        no_idle = 1'b1;
        queue_random(RANDOM_ITEMS / 3);
        drain_input();
        no_idle = 1'b0;

        hold_req = hold_req + 1;
        queue_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        drain_input();

        // A long run of ticks, then fades across wide spans.
        queue_cmd(fpwm_pkg::CMD_SET, 8'd30);
        queue_ticks(300);
        queue_cmd(fpwm_pkg::CMD_FADE, 8'd80);
        queue_ticks(100);
        queue_cmd(fpwm_pkg::CMD_FADE, 8'd0);
        queue_ticks(100);
        drain_input();

        waited = 0;
        while (pwm_out_q.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (40) @(posedge i_clk);
        if (pwm_out_q.size() != 0)
            report("results never delivered", pwm_out_q.size(), 0);

        $display("Checked %0d tick results across %0d fade sets, %0d immediate sets",
                 ticks_checked, fades_seen, jumps_seen);
        $display("and %0d ignored commands, including a long tick run and a hold-off.",
                 ignored_seen);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
